### rtl/core/sha1_stream_hasher_macros.svh
// assertion macros for the sha1 stream hasher
`ifndef SHA1_STREAM_HASHER_MACROS_SVH
`define SHA1_STREAM_HASHER_MACROS_SVH

// implication checked on every clock edge outside reset
`define SHA_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication checked outside reset
`define SHA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### rtl/core/sha_pkg.sv
package sha_pkg;

  localparam logic [1:0] ACT_RESTART = 2'd0;
  localparam logic [1:0] ACT_ABSORB  = 2'd1;
  localparam logic [1:0] ACT_FINISH  = 2'd2;
  localparam logic [1:0] ACT_UNUSED  = 2'd3;

  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  localparam logic [31:0] H0 = 32'h67452301;
  localparam logic [31:0] H1 = 32'hEFCDAB89;
  localparam logic [31:0] H2 = 32'h98BADCFE;
  localparam logic [31:0] H3 = 32'h10325476;
  localparam logic [31:0] H4 = 32'hC3D2E1F0;

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LEN_SLOT = 6'd55;

  // byte source for a block store write
  localparam logic [1:0] WSRC_DATA = 2'd0;
  localparam logic [1:0] WSRC_PAD  = 2'd1;
  localparam logic [1:0] WSRC_ZERO = 2'd2;
  localparam logic [1:0] WSRC_LEN  = 2'd3;

  typedef struct packed {
    logic       init;       // load initial chain, clear counters
    logic       wr;         // write one byte at fill count, advance
    logic [1:0] wsrc;
    logic       add_len;    // add 8 to bit length
    logic       comp_start; // start compression of the block
    logic       set_done;
    logic       set_broken;
  } sha_cmd_t;

  typedef struct packed {
    logic [5:0] fill;
    logic       busy;
    logic       len_wrap;   // bit length is about to wrap on this add
  } sha_sts_t;

  function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
    rotl = (x << n) | (x >> (32 - n));
  endfunction

endpackage

### rtl/core/sha_stream_if.sv
interface sha_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] data_byte;
  modport source (output valid, action, data_byte, input ready);
  modport sink (input valid, action, data_byte, output ready);
endinterface

interface sha_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;
  logic        status;
  modport source (output valid, digest_word, word_index, last_word, status, input ready);
  modport sink (input valid, digest_word, word_index, last_word, status, output ready);
endinterface

### rtl/core/sha1_stream_hasher.sv
// sha1_stream_hasher: byte-serial SHA-1 engine.
// in_ch carries action (restart, absorb, finish) and data_byte; a request is
// taken when valid and ready are both high. out_ch returns result items:
// five digest words (index 0..4, last_word on index 4, status 0) per
// finish, or one error item (status 1) if the hash was corrupted.
// An absorb writes one byte into the block store; the 64th byte of a block
// starts a compression (a start step, loading the 16-word schedule window,
// 80 rounds and the return to idle), during which no request is accepted.
// A finish of an unfinished hash pads the block byte by byte (one or two
// blocks, each followed by a compression) and then emits one word per cycle
// from the output register while the receiver accepts it.
// Restart and absorb produce no result. Reset (rst, synchronous) loads the
// initial chain value and clears counters and flags.
// When the receiver stalls, the current word holds in the output register
// and emission pauses; no input is accepted until the last word is loaded.
module sha1_stream_hasher (
  input logic        clk,
  input logic        rst,
  sha_in_if.sink     in_ch,
  sha_out_if.source  out_ch
);

  sha_pkg::sha_cmd_t cmd;
  sha_pkg::sha_sts_t sts;
  logic        emit, emit_err, out_free;
  logic [2:0]  emit_index;
  logic [31:0] rd_word;

  assign out_free = !out_ch.valid || out_ch.ready;

  sha_control u_ctrl (
    .clk, .rst, .in_ch, .sts, .out_free, .cmd, .emit, .emit_index, .emit_err
  );

  sha_datapath u_dp (
    .clk, .rst, .cmd, .data_byte(in_ch.data_byte), .rd_index(emit_index),
    .sts, .rd_word
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (out_free) begin
      out_ch.valid <= emit;
      if (emit) begin
        out_ch.digest_word <= emit_err ? 32'd0 : rd_word;
        out_ch.word_index  <= emit_err ? 3'd0 : emit_index;
        out_ch.last_word   <= emit_err || (emit_index == 3'd4);
        out_ch.status      <= emit_err;
      end
    end
  end

endmodule

### rtl/core/sha_datapath.sv
module sha_datapath (
  input  logic                 clk,
  input  logic                 rst,
  input  sha_pkg::sha_cmd_t    cmd,
  input  logic [7:0]           data_byte,
  input  logic [2:0]           rd_index,
  output sha_pkg::sha_sts_t    sts,
  output logic [31:0]          rd_word
);

  logic [31:0] block_store [16];
  logic [31:0] w [16];
  logic [31:0] chain [5];
  logic [31:0] a, b, c, d, e;
  logic [5:0]  fill;
  logic [63:0] message_bits;
  logic [6:0]  round;
  logic        busy;
  logic        loading;
  logic [3:0]  load_idx;
  logic [7:0]  wbyte;
  logic [2:0]  len_sel;
  logic [31:0] f, k, wt, tmp, wnew;

  assign sts.fill     = fill;
  assign sts.busy     = busy;
  assign sts.len_wrap = (message_bits[63:3] == '1);
  assign rd_word      = chain[rd_index];

  // byte to store
  assign len_sel = 3'(fill - 6'd56);
  always_comb begin
    case (cmd.wsrc)
      sha_pkg::WSRC_DATA: wbyte = data_byte;
      sha_pkg::WSRC_PAD:  wbyte = sha_pkg::PAD_BYTE;
      sha_pkg::WSRC_ZERO: wbyte = 8'd0;
      default:            wbyte = message_bits[8 * (7 - len_sel) +: 8];
    endcase
  end

  // round function
  always_comb begin
    if (round < 7'd20) begin
      f = (b & c) | (~b & d); k = sha_pkg::K0;
    end else if (round < 7'd40) begin
      f = b ^ c ^ d; k = sha_pkg::K1;
    end else if (round < 7'd60) begin
      f = (b & c) | (b & d) | (c & d); k = sha_pkg::K2;
    end else begin
      f = b ^ c ^ d; k = sha_pkg::K3;
    end
    wnew = sha_pkg::rotl(w[13] ^ w[8] ^ w[2] ^ w[0], 1);
    wt   = (round < 7'd16) ? w[0] : wnew;
    tmp  = sha_pkg::rotl(a, 5) + f + e + wt + k;
  end

  // block store write port, big-endian byte lanes in 16 words
  always_ff @(posedge clk) begin
    if (cmd.wr) block_store[fill[5:2]][8 * (3 - fill[1:0]) +: 8] <= wbyte;
  end

  // schedule window: load 16 words, then shift one per round
  always_ff @(posedge clk) begin
    if (loading) begin
      for (int i = 0; i < 15; i++) w[i] <= w[i + 1];
      w[15] <= block_store[load_idx];
    end else if (busy) begin
      for (int i = 0; i < 15; i++) w[i] <= w[i + 1];
      w[15] <= wt;
    end
  end

  // control and chain registers
  always_ff @(posedge clk) begin
    if (rst || cmd.init) begin
      chain[0] <= sha_pkg::H0; chain[1] <= sha_pkg::H1; chain[2] <= sha_pkg::H2;
      chain[3] <= sha_pkg::H3; chain[4] <= sha_pkg::H4;
      fill <= '0; message_bits <= '0; busy <= 1'b0; loading <= 1'b0;
      load_idx <= '0; round <= '0;
    end else begin
      if (cmd.wr) fill <= fill + 6'd1;
      if (cmd.add_len) message_bits <= message_bits + 64'd8;
      if (cmd.comp_start) begin
        busy <= 1'b1; loading <= 1'b1; load_idx <= '0; round <= '0;
        a <= chain[0]; b <= chain[1]; c <= chain[2]; d <= chain[3]; e <= chain[4];
      end else if (loading) begin
        load_idx <= load_idx + 4'd1;
        if (load_idx == 4'd15) loading <= 1'b0;
      end else if (busy) begin
        e <= d; d <= c; c <= sha_pkg::rotl(b, 30); b <= a; a <= tmp;
        round <= round + 7'd1;
        if (round == 7'd79) begin
          busy <= 1'b0;
          fill <= '0;
          chain[0] <= chain[0] + tmp; chain[1] <= chain[1] + a;
          chain[2] <= chain[2] + sha_pkg::rotl(b, 30);
          chain[3] <= chain[3] + c; chain[4] <= chain[4] + d;
        end
      end
    end
  end

endmodule

### rtl/core/sha_control.sv
`include "sha1_stream_hasher_macros.svh"
module sha_control (
  input  logic              clk,
  input  logic              rst,
  sha_in_if.sink            in_ch,
  input  sha_pkg::sha_sts_t sts,
  input  logic              out_free,
  output sha_pkg::sha_cmd_t cmd,
  output logic              emit,
  output logic [2:0]        emit_index,
  output logic              emit_err
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PAD  = 3'd1;
  localparam logic [2:0] S_WAIT = 3'd2;
  localparam logic [2:0] S_EMIT = 3'd3;
  localparam logic [2:0] S_ABS  = 3'd4;

  logic [2:0] state, state_next;
  logic [2:0] idx, idx_next;
  logic       done, done_next, broken, broken_next;
  logic       second, second_next; // padding needs a length block after this one
  logic       pad_mode, pad_mode_next;
  logic       acc;

  assign in_ch.ready = (state == S_IDLE);
  assign acc = in_ch.valid && in_ch.ready;

  always_comb begin
    state_next = state; idx_next = idx; done_next = done; broken_next = broken;
    second_next = second;
    cmd = '0; emit = 1'b0; emit_index = idx; emit_err = broken;
    unique case (state)
      S_IDLE: begin
        if (acc) begin
          case (in_ch.action)
            sha_pkg::ACT_RESTART: begin
              cmd.init = 1'b1; done_next = 1'b0; broken_next = 1'b0;
            end
            sha_pkg::ACT_ABSORB: begin
              if (done || broken) broken_next = 1'b1;
              else begin
                cmd.wr = 1'b1; cmd.wsrc = sha_pkg::WSRC_DATA; cmd.add_len = 1'b1;
                if (sts.len_wrap) broken_next = 1'b1;
                if (sts.fill == 6'd63) state_next = S_ABS;
              end
            end
            sha_pkg::ACT_FINISH: begin
              idx_next = '0;
              if (broken || done) state_next = S_EMIT;
              else begin
                cmd.wr = 1'b1; cmd.wsrc = sha_pkg::WSRC_PAD;
                second_next = (sts.fill > sha_pkg::LEN_SLOT);
                // pad byte in the last slot fills the block at once
                state_next = (sts.fill == 6'd63) ? S_ABS : S_PAD;
              end
            end
            default: ;
          endcase
        end
      end
      S_ABS: begin
        cmd.comp_start = 1'b1; state_next = S_WAIT;
      end
      S_PAD: begin
        // fill zeros, length bytes go in slots 56..63 unless a second block follows
        cmd.wr = 1'b1;
        cmd.wsrc = (second || sts.fill <= sha_pkg::LEN_SLOT) ? sha_pkg::WSRC_ZERO
                                                             : sha_pkg::WSRC_LEN;
        if (sts.fill == 6'd63) begin
          state_next = S_WAIT; cmd.comp_start = 1'b1;
        end
      end
      S_WAIT: begin
        // busy is already high in the first cycle here
        if (!sts.busy) begin
          if (!pad_mode) state_next = S_IDLE;
          else if (second) begin
            second_next = 1'b0; state_next = S_PAD;
          end else begin
            done_next = 1'b1; state_next = S_EMIT;
          end
        end
      end
      S_EMIT: begin
        if (out_free) begin
          emit = 1'b1;
          idx_next = idx + 3'd1;
          if (broken || idx == 3'd4) state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // remembers that the current compression belongs to a finish
  always_comb begin
    pad_mode_next = pad_mode;
    if (state == S_IDLE && acc && in_ch.action == sha_pkg::ACT_FINISH) pad_mode_next = 1'b1;
    else if (state == S_IDLE) pad_mode_next = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; idx <= '0; done <= 1'b0; broken <= 1'b0; second <= 1'b0;
      pad_mode <= 1'b0;
    end else begin
      state <= state_next; idx <= idx_next; done <= done_next; broken <= broken_next;
      second <= second_next; pad_mode <= pad_mode_next;
    end
  end

  `SHA_ASSERT_IMP(a_ready_idle, clk, rst, in_ch.ready, state == S_IDLE)
  `SHA_ASSERT_IMP(a_emit_range, clk, rst, emit, idx <= 3'd4)
  `SHA_ASSERT_NEXT(a_start_busy, clk, rst, cmd.comp_start, sts.busy)

endmodule

### tb/sv/sha1_hash_checker.sv
`timescale 1ns / 100ps

module sha1_hash_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [1:0] in_action,
  input  logic [7:0] in_byte,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [31:0] out_word,
  input  logic [2:0] out_index,
  input  logic       out_last,
  input  logic       out_status,
  output int         fail_count,
  output int         words_pending
);

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
    logic        status;
  } digest_res_t;

  logic [31:0] chain [5];
  logic [7:0]  blk [64];
  int          fill;
  logic [63:0] bit_len;
  logic        done;
  logic        broken;
  digest_res_t digest_q [$];

  assign words_pending = digest_q.size();

  function automatic logic [31:0] rol(input logic [31:0] x, input int n);
    rol = (x << n) | (x >> (32 - n));
  endfunction

  // one 80-round block compression into the chain
  task automatic compress_block();
    logic [31:0] w [16];
    logic [31:0] a, b, c, d, e, f, k, tmp, wt;
    for (int t = 0; t < 16; t++)
      w[t] = {blk[4*t], blk[4*t+1], blk[4*t+2], blk[4*t+3]};
    a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3]; e = chain[4];
    for (int t = 0; t < 80; t++) begin
      if (t < 16) begin
        wt = w[t];
      end else begin
        wt = rol(w[(t+13)&15] ^ w[(t+8)&15] ^ w[(t+2)&15] ^ w[t&15], 1);
        w[t&15] = wt;
      end
      if (t < 20) begin
        f = (b & c) | (~b & d); k = sha_pkg::K0;
      end else if (t < 40) begin
        f = b ^ c ^ d; k = sha_pkg::K1;
      end else if (t < 60) begin
        f = (b & c) | (b & d) | (c & d); k = sha_pkg::K2;
      end else begin
        f = b ^ c ^ d; k = sha_pkg::K3;
      end
      tmp = rol(a, 5) + f + e + wt + k;
      e = d; d = c; c = rol(b, 30); b = a; a = tmp;
    end
    chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d; chain[4] += e;
    fill = 0;
  endtask

  task automatic restart_hash();
    chain[0] = sha_pkg::H0; chain[1] = sha_pkg::H1; chain[2] = sha_pkg::H2;
    chain[3] = sha_pkg::H3; chain[4] = sha_pkg::H4;
    fill = 0; bit_len = '0; done = 1'b0; broken = 1'b0;
  endtask

  // predict the results of one request
  task automatic predict_request(input logic [1:0] act, input logic [7:0] db);
    digest_res_t r;
    case (act)
      sha_pkg::ACT_RESTART: begin
        restart_hash();
      end
      sha_pkg::ACT_ABSORB: begin
        if (done || broken) begin
          broken = 1'b1;
        end else begin
          blk[fill] = db;
          fill++;
          bit_len += 64'd8;
          if (bit_len == '0) broken = 1'b1;
          if (fill >= 64) compress_block();
        end
      end
      sha_pkg::ACT_FINISH: begin
        if (broken) begin
          r = '{word: '0, index: '0, last: 1'b1, status: 1'b1};
          digest_q.push_back(r);
        end else begin
          if (!done) begin
            blk[fill] = sha_pkg::PAD_BYTE;
            fill++;
            if (fill > 56) begin
              while (fill < 64) begin
                blk[fill] = '0; fill++;
              end
              compress_block();
            end
            while (fill < 56) begin
              blk[fill] = '0; fill++;
            end
            for (int i = 0; i < 8; i++) blk[56+i] = bit_len[63-8*i -: 8];
            compress_block();
            done = 1'b1;
          end
          for (int i = 0; i < 5; i++) begin
            r = '{word: chain[i], index: 3'(i), last: (i == 4), status: 1'b0};
            digest_q.push_back(r);
          end
        end
      end
      default: ;
    endcase
  endtask

  // watch both channels and compare
  always @(posedge clk) begin
    digest_res_t exp_r;
    int errs;
    errs = 0;
    if (rst) begin
      restart_hash();
      digest_q.delete();
      fail_count <= 0;
    end else begin
      if (in_valid && in_ready) predict_request(in_action, in_byte);
      if (out_valid && out_ready) begin
        if (digest_q.size() == 0) begin
          $error("unexpected result word %h", out_word);
          errs++;
        end else begin
          exp_r = digest_q.pop_front();
          if (out_word !== exp_r.word) begin
            $error("digest_word expected %h actual %h", exp_r.word, out_word);
            errs++;
          end
          if (out_index !== exp_r.index) begin
            $error("word_index expected %0d actual %0d", exp_r.index, out_index);
            errs++;
          end
          if (out_last !== exp_r.last) begin
            $error("last_word expected %0d actual %0d", exp_r.last, out_last);
            errs++;
          end
          if (out_status !== exp_r.status) begin
            $error("status expected %0d actual %0d", exp_r.status, out_status);
            errs++;
          end
        end
      end
      if (errs != 0) fail_count <= fail_count + errs;
    end
  end

endmodule

### tb/sv/sha1_stream_hasher_test.sv
`timescale 1ns / 100ps

module sha1_stream_hasher_test;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   fail_count;
  int   words_pending;
  logic hold_off = 1'b0;

  sha_in_if  in_ch ();
  sha_out_if out_ch ();

  sha1_stream_hasher u_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  sha1_hash_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_ch.valid),
    .in_ready     (in_ch.ready),
    .in_action    (in_ch.action),
    .in_byte      (in_ch.data_byte),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .out_word     (out_ch.digest_word),
    .out_index    (out_ch.word_index),
    .out_last     (out_ch.last_word),
    .out_status   (out_ch.status),
    .fail_count   (fail_count),
    .words_pending(words_pending)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.action = sha_pkg::ACT_RESTART;
    in_ch.data_byte = '0;
  end

  // send one request, with a random gap before it
  task automatic send_request(input logic [1:0] act, input logic [7:0] db);
    int gap;
    gap = $urandom_range(0, 3);
    repeat (gap) @(negedge clk);
    in_ch.valid <= 1'b1;
    in_ch.action <= act;
    in_ch.data_byte <= db;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
    in_ch.valid <= 1'b0;
  endtask

  task automatic send_message(input int len);
    send_request(sha_pkg::ACT_RESTART, 8'($urandom));
    for (int i = 0; i < len; i++) send_request(sha_pkg::ACT_ABSORB, 8'($urandom));
    send_request(sha_pkg::ACT_FINISH, 8'($urandom));
  endtask

  // receiver: random wait per word, plus one long hold-off
  initial begin : receiver
    int stall;
    out_ch.ready = 1'b0;
    @(negedge clk);
    forever begin
      stall = $urandom_range(0, 3);
      while (rst || hold_off || stall > 0) begin
        out_ch.ready <= 1'b0;
        if (stall > 0) stall--;
        @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid && !hold_off) @(posedge clk);
      @(negedge clk);
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    // directed: empty message, byte extremes, block edges
    send_message(0);
    send_request(sha_pkg::ACT_FINISH, 8'h00);
    send_request(sha_pkg::ACT_RESTART, 8'h00);
    send_request(sha_pkg::ACT_ABSORB, 8'h00);
    send_request(sha_pkg::ACT_ABSORB, 8'hff);
    send_request(sha_pkg::ACT_ABSORB, 8'haa);
    send_request(sha_pkg::ACT_ABSORB, 8'h55);
    send_request(sha_pkg::ACT_FINISH, 8'hff);
    // absorb after finish corrupts the hash
    send_request(sha_pkg::ACT_ABSORB, 8'h12);
    send_request(sha_pkg::ACT_FINISH, 8'h00);
    send_request(sha_pkg::ACT_ABSORB, 8'h34);
    send_request(sha_pkg::ACT_FINISH, 8'h00);
    // unused action code is ignored
    send_request(sha_pkg::ACT_UNUSED, 8'hff);
    // length fits the first block; full block then pad in the last slot
    send_message(55);
    send_message(127);
    // hold the receiver off while requests keep coming
    hold_off <= 1'b1;
    fork
      begin
        repeat (400) @(negedge clk);
        hold_off <= 1'b0;
      end
      begin
        send_message(3);
        send_message(1);
        send_message(2);
      end
    join
    // random: mostly well-formed messages, some noise
    for (int n = 0; n < 2; n++) begin
      if ($urandom_range(0, 4) == 0) begin
        for (int i = 0; i < 4; i++) send_request(2'($urandom), 8'($urandom));
      end else begin
        send_message($urandom_range(0, 12));
        if ($urandom_range(0, 3) == 0) send_request(sha_pkg::ACT_FINISH, 8'($urandom));
      end
    end
    while (words_pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0) begin
      $display("sha1_stream_hasher test passed");
    end else begin
      $display("sha1_stream_hasher test failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("sha1_stream_hasher test failed");
    $finish;
  end

endmodule

### sha1_stream_hasher.f
+incdir+rtl/core
rtl/core/sha_pkg.sv
rtl/core/sha_stream_if.sv
rtl/core/sha_datapath.sv
rtl/core/sha_control.sv
rtl/core/sha1_stream_hasher.sv
tb/sv/sha1_hash_checker.sv
tb/sv/sha1_stream_hasher_test.sv
